>>> hw/rtl/float64_box_to_int32_top_defines.svh
// ----------------------------------------------------------------------------
// float64_box_to_int32_top_defines
// Assertion macros used by the RTL of the double classifier.
// ----------------------------------------------------------------------------
`ifndef FLOAT64_BOX_TO_INT32_TOP_DEFINES_SVH
`define FLOAT64_BOX_TO_INT32_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define F64B_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define F64B_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> hw/rtl/f64b_pkg.sv
// ----------------------------------------------------------------------------
// f64b_pkg
// Kind codes, binary64 field constants and the decode record for the
// double classifier.
// ----------------------------------------------------------------------------
package f64b_pkg;

    localparam int unsigned KindW   = 3;
    localparam int unsigned FracW   = 52;
    localparam int unsigned ExpW    = 11;
    localparam int unsigned MantW   = FracW + 1;
    localparam int unsigned MagW    = 31;
    localparam int unsigned IntExpW = 5;
    localparam int unsigned ShiftW  = 6;

    localparam logic [KindW-1:0] KIND_INT  = 3'd0;
    localparam logic [KindW-1:0] KIND_NAN  = 3'd1;
    localparam logic [KindW-1:0] KIND_PINF = 3'd2;
    localparam logic [KindW-1:0] KIND_MINF = 3'd3;
    localparam logic [KindW-1:0] KIND_KEPT = 3'd4;

    localparam logic [ExpW-1:0] EXP_BIAS    = 11'h3ff;
    localparam logic [ExpW-1:0] EXP_ALLONES = 11'h7ff;
    localparam logic [ExpW-1:0] EXP_INT_TOP = EXP_BIAS + 11'd30;
    localparam logic [31:0]     INT_MIN_HI  = 32'hc1e0_0000;
    localparam logic [31:0]     INT_MIN_VAL = 32'h8000_0000;

    // Outcome of the field decode. fixed covers every pattern whose result
    // needs no shifting: NaN, infinities, zero/subnormal and exactly -2^31.
    typedef struct packed {
        logic               fixed;
        logic [KindW-1:0]   fixed_kind;
        logic               fixed_min;
        logic               cand;       // unbiased exponent 0..30
        logic [IntExpW-1:0] e;
    } dec_t;

endpackage

>>> hw/rtl/f64b_decode.sv
// ----------------------------------------------------------------------------
// f64b_decode
// Splits a binary64 pattern into its fields and sorts it into the fixed
// outcomes and the candidates for an exact integer.
// ----------------------------------------------------------------------------
module f64b_decode (
    input  logic [63:0]    bits,
    output f64b_pkg::dec_t dec
);
    import f64b_pkg::*;

    logic             sign;
    logic [ExpW-1:0]  bexp;
    logic [FracW-1:0] frac;
    logic [ExpW-1:0]  e_full;

    assign sign   = bits[63];
    assign bexp   = bits[62:52];
    assign frac   = bits[51:0];
    assign e_full = bexp - EXP_BIAS;

    always_comb
    begin
        dec.fixed      = 1'b0;
        dec.fixed_kind = KIND_INT;
        dec.fixed_min  = 1'b0;
        dec.cand       = 1'b0;
        dec.e          = e_full[IntExpW-1:0];
        if (bexp == EXP_ALLONES)
        begin
            dec.fixed = 1'b1;
            if (frac != '0)
                dec.fixed_kind = KIND_NAN;
            else
                dec.fixed_kind = sign ? KIND_MINF : KIND_PINF;
        end
        else if (bexp == '0)
        begin
            dec.fixed = 1'b1;
        end
        else if (bexp >= EXP_BIAS && bexp <= EXP_INT_TOP)
        begin
            dec.cand = 1'b1;
        end
        else if (bits[63:32] == INT_MIN_HI && bits[31:0] == '0)
        begin
            // -2^31 is the one in-range value with exponent 31
            dec.fixed     = 1'b1;
            dec.fixed_min = 1'b1;
        end
    end

endmodule

>>> hw/rtl/float64_box_to_int32_top.sv
// ----------------------------------------------------------------------------
// float64_box_to_int32_top
// Classifies a binary64 pattern as integer, NaN, +/-infinity or kept double.
// ----------------------------------------------------------------------------
// Throughput is one transaction per cycle when the output is not stalled;
// the three register stages are field decode, mantissa shift and fraction
// test, and sign apply into the output register. Each stage holds under
// backpressure independently, so bubbles are squeezed out during a stall.
`include "float64_box_to_int32_top_defines.svh"

module float64_box_to_int32_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [63:0]                  double_bits,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [f64b_pkg::KindW-1:0]   kind,
    output logic signed [31:0]           int_value,
    output logic [63:0]                  kept_bits
);
    import f64b_pkg::*;

    dec_t dec;

    // stage 1: decode
    logic             v1_reg, v1_next;
    dec_t             dec1_reg;
    logic [63:0]      bits1_reg;

    // stage 2: shift and exactness test
    logic             v2_reg, v2_next;
    dec_t             dec2_reg;
    logic [63:0]      bits2_reg;
    logic [MagW-1:0]  mag2_reg;
    logic             exact2_reg;

    // stage 3: output
    logic             v3_reg, v3_next;

    logic adv1, adv2, adv3;

    logic [ShiftW-1:0] sh;
    logic [MantW-1:0]  mant;
    logic [FracW-1:0]  lowmask;
    logic [MantW-1:0]  shifted;
    logic [31:0]       mag_ext;
    logic [31:0]       sval;

    f64b_decode u_decode (
        .bits (double_bits),
        .dec  (dec)
    );

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        v1_next = adv1 ? in_valid : v1_reg;
        v2_next = adv2 ? v1_reg   : v2_reg;
        v3_next = adv3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // shift of 52 - e, e in 0..30
    assign sh      = ShiftW'(FracW) - ShiftW'(dec1_reg.e);
    assign mant    = {1'b1, bits1_reg[51:0]};
    assign lowmask = FracW'((64'd1 << sh) - 64'd1);
    assign shifted = mant >> sh;

    assign mag_ext = {1'b0, mag2_reg};
    assign sval    = bits2_reg[63] ? (32'd0 - mag_ext) : mag_ext;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            dec1_reg  <= dec;
            bits1_reg <= double_bits;
        end
        if (adv2)
        begin
            dec2_reg   <= dec1_reg;
            bits2_reg  <= bits1_reg;
            mag2_reg   <= shifted[MagW-1:0];
            exact2_reg <= (bits1_reg[51:0] & lowmask) == '0;
        end
        if (adv3)
        begin
            if (dec2_reg.fixed)
            begin
                kind      <= dec2_reg.fixed_kind;
                int_value <= dec2_reg.fixed_min ? INT_MIN_VAL : 32'd0;
                kept_bits <= '0;
            end
            else if (dec2_reg.cand && exact2_reg)
            begin
                kind      <= KIND_INT;
                int_value <= sval;
                kept_bits <= '0;
            end
            else
            begin
                kind      <= KIND_KEPT;
                int_value <= 32'd0;
                kept_bits <= bits2_reg;
            end
        end
    end

    assign out_valid = v3_reg;

    `F64B_ASSERT_NOW(a_int_zero, out_valid && kind != KIND_INT, int_value == 32'sd0)
    `F64B_ASSERT_NOW(a_kept_zero, out_valid && kind != KIND_KEPT, kept_bits == 64'd0)
    `F64B_ASSERT_NOW(a_kept_finite, out_valid && kind == KIND_KEPT,
                     kept_bits[62:52] != EXP_ALLONES && kept_bits[62:52] != 11'd0)
    `F64B_ASSERT_NOW(a_kind_range, out_valid, kind <= KIND_KEPT)
    `F64B_ASSERT_NEXT(a_stage2_moves, v2_reg && adv3, out_valid)

endmodule
